// ----- hdl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// 3x3 mean filter: shared package
// Widths, codes and the step command that the front end hands to the back end.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W              = 8;
  localparam int FRAME_W_BITS       = 11;
  localparam int FRAME_H_BITS       = 13;
  localparam int CFG_W              = 13;
  localparam int ROW_W              = 14;
  localparam int QUEUE_DEPTH        = 4;
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Control for one stream step. The masks select which window rows and
  // columns lie inside the frame for the output made by this step.
  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } step_ctl_t;

endpackage

// ----- hdl/mean_filter_3x3_zero_pad.sv -----
// ----------------------------------------------------------------------------
// 3x3 mean filter with zero padding
//
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  s_tdata = pixel_in, s_tuser = operation
// m_*      out        m_tvalid/m_tready  m_tdata = mean_out, m_tlast = frame_last
// cfg_*    in         cfg_we             cfg_index, cfg_data (width, height)
//
// One item is taken per cycle while s_tready is high; a result passes the
// step queue, the line store read, the sum stage and the divide stage
// before it leaves the output register.
// After the last pixel of a single-row frame the front end inserts one
// internal step, holding s_tready low until that step enters the queue.
// rst clears counters, queue, window and output valid; the line stores are
// not cleared and need no clearing pass.
// m_tready low while m_tvalid is high freezes the back end; the four-entry queue absorbs input.
// ----------------------------------------------------------------------------
module mean_filter_3x3_zero_pad #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_data,   // frame_width [10:0] or frame_height [12:0]
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,    // [7:0] pixel_in
  input  logic [0:0]                s_tuser,    // [0] operation
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,    // [7:0] mean_out
  output logic                      m_tlast
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int DATA_W = $bits(mf3_pkg::step_ctl_t) + CW + mf3_pkg::PIX_W;

  logic                      q_ready;
  logic                      cmd_valid;
  mf3_pkg::step_ctl_t        cmd_ctl;
  logic [CW-1:0]             cmd_col;
  logic [mf3_pkg::PIX_W-1:0] cmd_pix;
  logic [DATA_W-1:0]         q_in;
  logic [DATA_W-1:0]         q_out;
  logic                      head_valid;
  logic                      head_ready;
  mf3_pkg::step_ctl_t        head_ctl;
  logic [CW-1:0]             head_col;
  logic [mf3_pkg::PIX_W-1:0] head_pix;

  mf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_ready   (q_ready),
    .cmd_valid (cmd_valid),
    .cmd_ctl   (cmd_ctl),
    .cmd_col   (cmd_col),
    .cmd_pix   (cmd_pix)
  );

  assign q_in = {cmd_ctl, cmd_col, cmd_pix};

  mf3_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_valid),
    .in_ready  (q_ready),
    .in_data   (q_in),
    .out_valid (head_valid),
    .out_ready (head_ready),
    .out_data  (q_out)
  );

  assign {head_ctl, head_col, head_pix} = q_out;

  mf3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd_ready (head_ready),
    .cmd_ctl   (head_ctl),
    .cmd_col   (head_col),
    .cmd_pix   (head_pix),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- hdl/mf3_queue.sv -----
// ----------------------------------------------------------------------------
// 3x3 mean filter: step queue
// Small FIFO that separates the front end from the back end.
// ----------------------------------------------------------------------------
module mf3_queue #(
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  localparam int DEPTH = mf3_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;
  logic              push;
  logic              pop;

  assign in_ready  = count < (PW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> in_ready)
    else $error("step offered to a full queue");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + (PW+1)'(1))
    else $error("queue count lost a step");

endmodule

// ----- hdl/mf3_front.sv -----
// ----------------------------------------------------------------------------
// 3x3 mean filter: front end
// Holds the frame size and position counters, classifies each input item and
// issues stream steps with their border masks into the step queue.
// ----------------------------------------------------------------------------
module mf3_front #(
  parameter  int MAX_WIDTH = 1024,
  localparam int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [mf3_pkg::PIX_W-1:0]    s_tdata,
  input  logic [0:0]                   s_tuser,
  input  logic                         q_ready,
  output logic                         cmd_valid,
  output mf3_pkg::step_ctl_t           cmd_ctl,
  output logic [CW-1:0]                cmd_col,
  output logic [mf3_pkg::PIX_W-1:0]    cmd_pix
);

  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int XW      = WW + 1;
  localparam int RW      = mf3_pkg::ROW_W;
  localparam int HW      = mf3_pkg::FRAME_H_BITS;
  localparam int RESET_W = (mf3_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : mf3_pkg::FRAME_WIDTH_RESET;

  logic [WW-1:0] w_use;
  logic [WW-1:0] w_cfg;
  logic [HW-1:0] h_use;
  logic [HW-1:0] h_cfg;
  int            fw_int;
  logic [CW-1:0] in_col;
  logic [CW-1:0] out_col;
  logic [RW-1:0] in_row;
  logic [RW-1:0] out_row;
  logic          input_done;
  logic [RW-1:0] h_ext;
  logic          in_col_end;
  logic          out_col_end;
  logic          in_row_end;
  logic          out_row_end;
  logic          emit;
  logic          auto_step;
  logic          take;
  logic          pix_op;
  logic          step;

  always_comb begin
    fw_int = int'(cfg_data[mf3_pkg::FRAME_W_BITS-1:0]);
    if (fw_int == 0) begin
      w_cfg = WW'(1);
    end else if (fw_int > MAX_WIDTH) begin
      w_cfg = WW'(MAX_WIDTH);
    end else begin
      w_cfg = WW'(fw_int);
    end
    h_cfg = (cfg_data[HW-1:0] == '0) ? HW'(1) : cfg_data[HW-1:0];
  end

  assign h_ext       = RW'(h_use);
  assign in_col_end  = (XW'(in_col) + XW'(1)) >= XW'(w_use);
  assign out_col_end = (XW'(out_col) + XW'(1)) >= XW'(w_use);
  assign in_row_end  = (in_row + RW'(1)) >= h_ext;
  assign out_row_end = (out_row + RW'(1)) >= h_ext;
  assign emit        = ((in_row >= RW'(2)) || (in_row == RW'(1) && in_col != '0)) &&
                       (out_row < h_ext);

  // A single-row frame needs one silent step after its last pixel so that
  // every drain that follows yields an output.
  assign auto_step = input_done && !emit;
  assign s_tready  = q_ready && !auto_step;
  assign take      = s_tvalid && s_tready;
  assign pix_op    = s_tuser[0] == mf3_pkg::OP_PIXEL;
  assign step      = auto_step ? q_ready : (take && (pix_op ? !input_done : input_done));

  assign cmd_valid        = step;
  assign cmd_col          = in_col;
  assign cmd_pix          = auto_step ? '0 : s_tdata;
  assign cmd_ctl.emit     = emit;
  assign cmd_ctl.last     = out_row_end && out_col_end;
  assign cmd_ctl.top_ok   = out_row != '0;
  assign cmd_ctl.bot_ok   = !out_row_end;
  assign cmd_ctl.left_ok  = out_col != '0;
  assign cmd_ctl.right_ok = (in_col != '0) && !out_col_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_use      <= WW'(RESET_W);
      h_use      <= HW'(mf3_pkg::FRAME_HEIGHT_RESET);
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      input_done <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mf3_pkg::REG_FRAME_WIDTH:  w_use <= w_cfg;
        mf3_pkg::REG_FRAME_HEIGHT: h_use <= h_cfg;
        default: ;
      endcase
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      input_done <= 1'b0;
    end else if (step) begin
      if (in_col_end) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
      if (!auto_step && pix_op && in_row_end && in_col_end) begin
        input_done <= 1'b1;
      end
      if (emit) begin
        if (out_col_end) begin
          out_col <= '0;
          out_row <= out_row + RW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
        if (out_col_end && out_row_end) begin
          in_col     <= '0;
          in_row     <= '0;
          out_col    <= '0;
          out_row    <= '0;
          input_done <= 1'b0;
        end
      end
    end
  end

  a_done_means_rows_in: assert property (@(posedge clk) disable iff (rst)
    input_done |-> in_row >= h_ext)
    else $error("input marked done before the last row arrived");

  a_out_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_row < h_ext)
    else $error("output row ran past the frame");

  a_drain_emits: assert property (@(posedge clk) disable iff (rst)
    (take && !pix_op && input_done) |-> emit)
    else $error("owed drain did not produce an output");

endmodule

// ----- hdl/mf3_back.sv -----
// ----------------------------------------------------------------------------
// 3x3 mean filter: back end
// Line store, window columns, masked sum, divide by nine and output register.
// ----------------------------------------------------------------------------
module mf3_back #(
  parameter  int MAX_WIDTH = 1024,
  localparam int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  mf3_pkg::step_ctl_t        cmd_ctl,
  input  logic [CW-1:0]             cmd_col,
  input  logic [mf3_pkg::PIX_W-1:0] cmd_pix,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [mf3_pkg::PIX_W-1:0] m_tdata,
  output logic                      m_tlast
);

  localparam int PW    = mf3_pkg::PIX_W;
  localparam int CSW   = PW + 2;
  localparam int SUM_W = PW + 4;
  localparam int RECIP = 7282;
  localparam int SHIFT = 16;
  localparam int PRODW = SUM_W + 13;

  typedef struct packed {
    logic [PW-1:0] top;
    logic [PW-1:0] mid;
    logic [PW-1:0] bot;
  } pix_col_t;

  function automatic logic [CSW-1:0] col_sum(pix_col_t c, logic top_ok, logic bot_ok);
    logic [CSW-1:0] s;
    s = CSW'(c.mid) + (top_ok ? CSW'(c.top) : '0) + (bot_ok ? CSW'(c.bot) : '0);
    return s;
  endfunction

  // Exact for every sum up to nine full-scale pixels.
  function automatic logic [PW-1:0] div9(logic [SUM_W-1:0] s);
    logic [PRODW-1:0] p;
    p = PRODW'(s) * PRODW'(RECIP);
    return p[SHIFT +: PW];
  endfunction

  logic [2*PW-1:0]    line_mem [MAX_WIDTH];
  logic [2*PW-1:0]    mem_q;
  logic               byp_hit;
  logic [2*PW-1:0]    byp_data;
  logic               adv;
  logic               s1_valid;
  mf3_pkg::step_ctl_t s1_ctl;
  logic [CW-1:0]      s1_col;
  logic [PW-1:0]      s1_pix;
  logic [PW-1:0]      top_pix;
  logic [PW-1:0]      mid_pix;
  logic [2*PW-1:0]    wr_data;
  pix_col_t           new_col;
  pix_col_t           win_l;
  pix_col_t           win_c;
  logic [CSW-1:0]     sum_l;
  logic [CSW-1:0]     sum_c;
  logic [CSW-1:0]     sum_r;
  logic [SUM_W-1:0]   sum;
  logic               s2_valid;
  logic               s2_last;
  logic [SUM_W-1:0]   s2_sum;

  assign adv       = !m_tvalid || m_tready;
  assign cmd_ready = adv;

  assign top_pix = byp_hit ? byp_data[2*PW-1:PW] : mem_q[2*PW-1:PW];
  assign mid_pix = byp_hit ? byp_data[PW-1:0] : mem_q[PW-1:0];
  assign wr_data = {mid_pix, s1_pix};
  assign new_col = '{top: top_pix, mid: mid_pix, bot: s1_pix};

  always_comb begin
    sum_l = s1_ctl.left_ok ? col_sum(win_l, s1_ctl.top_ok, s1_ctl.bot_ok) : '0;
    sum_c = col_sum(win_c, s1_ctl.top_ok, s1_ctl.bot_ok);
    sum_r = s1_ctl.right_ok ? col_sum(new_col, s1_ctl.top_ok, s1_ctl.bot_ok) : '0;
    sum   = SUM_W'(sum_l) + SUM_W'(sum_c) + SUM_W'(sum_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q <= line_mem[cmd_col];
      if (s1_valid) begin
        line_mem[s1_col] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl   <= cmd_ctl;
      s1_col   <= cmd_col;
      s1_pix   <= cmd_pix;
      byp_hit  <= s1_valid && (cmd_col == s1_col);
      byp_data <= wr_data;
      s2_sum   <= sum;
      s2_last  <= s1_ctl.last;
      m_tdata  <= div9(s2_sum);
      m_tlast  <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
      win_l    <= '0;
      win_c    <= '0;
    end else if (adv) begin
      s1_valid <= cmd_valid;
      s2_valid <= s1_valid && s1_ctl.emit;
      m_tvalid <= s2_valid;
      if (s1_valid) begin
        win_l <= win_c;
        win_c <= new_col;
      end
    end
  end

endmodule

// ----- tb/mean_filter_3x3_zero_pad_test.sv -----
// ----------------------------------------------------------------------------
// 3x3 mean filter with zero padding: self-checking testbench
// A built-in predictor of the windowed mean tracks every accepted transfer and
// queues the expected outputs, which are compared field by field as they leave.
// A short scripted part covers clamped sizes, tiny frames and ignored items;
// random frames with broken and noisy sequences follow under random flow control.
// ----------------------------------------------------------------------------
module mean_filter_3x3_zero_pad_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int SETTLE_CYC   = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    logic [7:0] mean;
    logic       last;
  } avg_pixel_t;

  typedef struct packed {
    logic       is_cfg;
    reg_idx_t   idx;
    logic [12:0] val;
    op_t        op;
    logic [7:0] pix;
    logic       typed;
    logic [7:0] mean;
    logic       last;
  } script_row_t;

  localparam script_row_t SCRIPT [0:30] = '{
    '{1'b1, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, REG_FRAME_HEIGHT, 13'd0,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd7,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd0,   1'b1, 8'd28,  1'b1},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, REG_FRAME_WIDTH,  13'd2,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, REG_FRAME_HEIGHT, 13'd2,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b1, 8'd113, 1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd0,   1'b1, 8'd113, 1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd0,   1'b1, 8'd113, 1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd0,   1'b1, 8'd113, 1'b1},
    '{1'b1, REG_FRAME_WIDTH,  13'h1803,   OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, REG_FRAME_HEIGHT, 13'd3,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd170, 1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd85,  1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH,  13'd0,      OP_DRAIN, 8'd255, 1'b0, 8'd0,   1'b0}
  };

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;
  logic [0:0]        s_tuser   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;

  mean_filter_3x3_zero_pad #(.MAX_WIDTH(MAX_WIDTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [10:0]       cfg_width;
  logic [12:0]       cfg_height;
  logic [7:0]        line_prev  [MAX_WIDTH];
  logic [7:0]        line_prev2 [MAX_WIDTH];
  logic [2:0][7:0]   win [3];
  int unsigned       in_col, in_row, out_col, out_row;
  bit                input_done;

  avg_pixel_t        pending_means [$];
  avg_pixel_t        seen_exp;
  int                errors     = 0;
  int unsigned       cycles     = 0;
  int unsigned       work_items = 0;
  int unsigned       burst_left = 0;
  logic              rx_open    = 1'b0;
  int unsigned       rx_mode    = 0;
  int unsigned       rx_left    = 0;

  function automatic int unsigned width_used();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return cfg_width;
  endfunction

  function automatic int unsigned height_used();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    input_done = 1'b0;
  endfunction

  function automatic void filter_reset();
    cfg_width = 11'(FRAME_WIDTH_RESET);
    cfg_height = 13'(FRAME_HEIGHT_RESET);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    for (int c = 0; c < 3; c++) win[c] = '0;
    restart_frame();
  endfunction

  function automatic void filter_config(reg_idx_t idx, logic [12:0] val);
    if (idx == REG_FRAME_WIDTH) cfg_width = val[10:0];
    else cfg_height = val;
    restart_frame();
  endfunction

  function automatic void shift_column(logic [7:0] t, logic [7:0] m, logic [7:0] b);
    win[0] = win[1];
    win[1] = win[2];
    win[2] = {b, m, t};
  endfunction

  function automatic int unsigned column_sum(int c, int unsigned h);
    int unsigned s;
    s = win[c][1];
    if (out_row >= 1) s += win[c][0];
    if (out_row + 1 < h) s += win[c][2];
    return s;
  endfunction

  function automatic bit window_step(logic [7:0] pix, output avg_pixel_t res);
    int unsigned w, h, x, idx, sum;
    logic [7:0] t, m;
    bit emit, made;
    int lc, cc, rc;
    w = width_used();
    h = height_used();
    x = in_col;
    idx = (x < MAX_WIDTH) ? x : MAX_WIDTH - 1;
    t = line_prev2[idx];
    m = line_prev[idx];
    emit = (in_row >= 2 || (in_row == 1 && x >= 1)) && out_row < h;
    line_prev2[idx] = m;
    line_prev[idx] = pix;
    if (x == 0) begin
      lc = 1; cc = 2; rc = -1;
    end else begin
      shift_column(t, m, pix);
      lc = 0; cc = 1; rc = 2;
    end
    made = 1'b0;
    res = '0;
    if (emit) begin
      res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
      sum = column_sum(cc, h);
      if (out_col >= 1) sum += column_sum(lc, h);
      if (rc >= 0 && out_col + 1 < w) sum += column_sum(rc, h);
      res.mean = 8'(sum / 9);
      made = 1'b1;
    end
    if (x == 0) shift_column(t, m, pix);
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < 32'hFFFF) in_row++;
    end else begin
      in_col++;
    end
    if (made) begin
      if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= height_used()) restart_frame();
      end else begin
        out_col++;
      end
    end
    return made;
  endfunction

  function automatic bit filter_item(op_t op, logic [7:0] pix, output avg_pixel_t res);
    bit last_in, made;
    res = '0;
    if (op == OP_PIXEL) begin
      if (input_done) return 1'b0;
      last_in = (in_row + 1 >= height_used()) && (in_col + 1 >= width_used());
      made = window_step(pix, res);
      if (last_in) input_done = 1'b1;
      return made;
    end
    if (!input_done) return 1'b0;
    if (window_step(8'd0, res)) return 1'b1;
    return window_step(8'd0, res);
  endfunction

  task automatic send_item(input op_t op, input logic [7:0] pix,
                           output bit made, output avg_pixel_t res);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    made = filter_item(op, pix, res);
  endtask

  task automatic feed(input op_t op, input logic [7:0] pix);
    bit taken, made;
    avg_pixel_t res;
    taken = (op == OP_PIXEL) ? !input_done : input_done;
    send_item(op, pix, made, res);
    if (made) pending_means.push_back(res);
    if (taken) work_items++;
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    rx_open <= 1'b1;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    rx_open <= 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    filter_config(idx, val);
    @(posedge clk);
  endtask

  task automatic run_frame(input bit abandon);
    int unsigned total, cut;
    total = width_used() * height_used();
    cut = abandon ? $urandom_range(total - 1) : total;
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(19) == 0) feed(OP_DRAIN, 8'($urandom));
      feed(OP_PIXEL, 8'($urandom));
    end
    if (!abandon) begin
      while (input_done) begin
        if ($urandom_range(6) == 0) feed(OP_PIXEL, 8'($urandom));
        feed(OP_DRAIN, 8'($urandom));
      end
    end
  endtask

  task automatic pick_config(input bit both);
    logic [10:0] w;
    logic [12:0] h;
    case ($urandom_range(19))
      0:       w = 11'd0;
      1:       w = 11'($urandom_range(41, 200));
      2, 3:    w = 11'($urandom_range(9, 40));
      default: w = 11'($urandom_range(1, 8));
    endcase
    if (w > 8) begin
      h = 13'($urandom_range(3));
    end else begin
      case ($urandom_range(9))
        0:       h = 13'd0;
        1:       h = 13'($urandom_range(7, 24));
        default: h = 13'($urandom_range(1, 6));
      endcase
    end
    quiesce();
    case ($urandom_range(2))
      0: begin
        write_reg(REG_FRAME_WIDTH, {2'($urandom), w});
        write_reg(REG_FRAME_HEIGHT, h);
      end
      1: begin
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_FRAME_WIDTH, {2'($urandom), w});
      end
      default: begin
        write_reg(REG_FRAME_WIDTH, {2'($urandom), w});
        if (both || cfg_height > 3) write_reg(REG_FRAME_HEIGHT, h);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_left <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(3);
        rx_left <= $urandom_range(4, 40);
      end else begin
        rx_left <= rx_left - 1;
      end
      if (rx_open) m_tready <= 1'b1;
      else begin
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ~m_tready;
          2:       m_tready <= ($urandom_range(9) < 7);
          default: m_tready <= (rx_left % 5 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected transfer: mean_out %0d, frame_last %0d", m_tdata, m_tlast);
        errors++;
      end else begin
        seen_exp = pending_means.pop_front();
        if (m_tdata !== seen_exp.mean) begin
          $error("mean_out: expected %0d, actual %0d", seen_exp.mean, m_tdata);
          errors++;
        end
        if (m_tlast !== seen_exp.last) begin
          $error("frame_last: expected %0d, actual %0d", seen_exp.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    bit made;
    bit need_cfg;
    bit abandon;
    avg_pixel_t res;
    filter_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) begin
        quiesce();
        write_reg(SCRIPT[i].idx, SCRIPT[i].val);
      end else begin
        send_item(SCRIPT[i].op, SCRIPT[i].pix, made, res);
        if (made && SCRIPT[i].typed) pending_means.push_back({SCRIPT[i].mean, SCRIPT[i].last});
        else if (made) pending_means.push_back(res);
      end
    end

    // Widest row in a single-row frame, then a very tall frame cut short.
    quiesce();
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    run_frame(1'b0);
    quiesce();
    write_reg(REG_FRAME_WIDTH, 13'd5);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 60; i++) feed(OP_PIXEL, 8'($urandom));

    need_cfg = 1'b1;
    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      if (need_cfg || $urandom_range(3) != 0) pick_config(need_cfg);
      abandon = ($urandom_range(7) == 0);
      run_frame(abandon);
      need_cfg = abandon;
      if ($urandom_range(9) == 0) feed(OP_DRAIN, 8'($urandom));
      if ($urandom_range(9) == 0) quiesce();
    end

    s_tvalid <= 1'b0;
    rx_open <= 1'b1;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mf3_pkg.sv
hdl/mf3_queue.sv
hdl/mf3_front.sv
hdl/mf3_back.sv
hdl/mean_filter_3x3_zero_pad.sv
tb/mean_filter_3x3_zero_pad_test.sv
